// ===== rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // Configuration register widths and reset values
    localparam int DELAY_W = 16;
    localparam int POLL_W  = 8;
    localparam int BYTE_W  = 8;
    localparam int CMD_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DELAY_W;

    localparam logic [DELAY_W-1:0] DELAY_TICKS_RESET    = 16'd10;
    localparam logic [POLL_W-1:0]  ACK_POLL_LIMIT_RESET = 8'd250;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TICKS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL_LIMIT = 1'b1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEND  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WAIT  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd5;

    // Number of bits in a byte transfer
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_ST1     = 4'd1,
        PH_ST2     = 4'd2,
        PH_SP1     = 4'd3,
        PH_SP2     = 4'd4,
        PH_SP3     = 4'd5,
        PH_SB_HI   = 4'd6,
        PH_SB_LO   = 4'd7,
        PH_WA1     = 4'd8,
        PH_WA2     = 4'd9,
        PH_WA_POLL = 4'd10,
        PH_RB_HI   = 4'd11,
        PH_RB_LO   = 4'd12,
        PH_RA1     = 4'd13,
        PH_RA2     = 4'd14
    } phase_t;

    // One result word
    typedef struct packed {
        logic              scl_out;
        logic              sda_out;
        logic              busy_res;
        logic              done_res;
        logic              nack;
        logic [BYTE_W-1:0] read_data;
    } result_t;

endpackage

// ===== rtl/i2cm_core.sv =====
// ----------------------------------------------------------------------------
// i2cm_core
// Bus sequencer state and its one-tick update; produces the result word
// of the current tick from the updated state.
// ----------------------------------------------------------------------------
module i2cm_core
    import i2cm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  logic [CMD_W-1:0]    command,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic                send_ack,
    input  logic                sda_in,
    input  logic [DELAY_W-1:0]  delay_ticks,
    input  logic [POLL_W-1:0]   ack_poll_limit,
    output result_t             result
);

    phase_t             phase_reg, phase_next;
    logic [3:0]         bit_index_reg, bit_index_next;
    logic [BYTE_W-1:0]  shifter_reg, shifter_next;
    logic [DELAY_W-1:0] delay_count_reg, delay_count_next;
    logic [POLL_W-1:0]  poll_count_reg, poll_count_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;
    logic               ack_choice_reg, ack_choice_next;
    logic               nack_reg, nack_next;
    logic [BYTE_W-1:0]  rx_hold_reg, rx_hold_next;
    logic               done;
    logic [DELAY_W-1:0] load_val;
    logic               expired;
    logic               polling;
    logic [3:0]         bit_inc;

    assign load_val = (delay_ticks == '0) ? DELAY_W'(1) : delay_ticks;
    assign expired  = (delay_count_reg <= DELAY_W'(1));
    assign polling  = (phase_reg == PH_WA_POLL) || ((phase_reg == PH_WA2) && expired);
    assign bit_inc  = bit_index_reg + 4'd1;

    // Compute the state after this tick
    always_comb begin
        phase_next       = phase_reg;
        bit_index_next   = bit_index_reg;
        shifter_next     = shifter_reg;
        delay_count_next = delay_count_reg;
        poll_count_next  = poll_count_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        ack_choice_next  = ack_choice_reg;
        nack_next        = nack_reg;
        rx_hold_next     = rx_hold_reg;
        done             = 1'b0;

        if (phase_reg == PH_IDLE) begin
            case (command)
                CMD_START: begin
                    sda_next         = 1'b1;
                    scl_next         = 1'b1;
                    delay_count_next = load_val;
                    phase_next       = PH_ST1;
                end
                CMD_STOP: begin
                    scl_next         = 1'b0;
                    sda_next         = 1'b0;
                    delay_count_next = load_val;
                    phase_next       = PH_SP1;
                end
                CMD_SEND: begin
                    scl_next         = 1'b0;
                    sda_next         = data_byte[BYTE_W-1];
                    shifter_next     = {data_byte[BYTE_W-2:0], 1'b0};
                    bit_index_next   = '0;
                    delay_count_next = load_val;
                    phase_next       = PH_SB_HI;
                end
                CMD_WAIT: begin
                    nack_next        = 1'b0;
                    poll_count_next  = '0;
                    sda_next         = 1'b1;
                    delay_count_next = load_val;
                    phase_next       = PH_WA1;
                end
                CMD_READ: begin
                    sda_next         = 1'b1;
                    scl_next         = 1'b0;
                    ack_choice_next  = send_ack;
                    shifter_next     = '0;
                    bit_index_next   = '0;
                    delay_count_next = load_val;
                    phase_next       = PH_RB_HI;
                end
                default: begin
                end
            endcase
        end else if (polling) begin
            // Sample the acknowledge slot, time out into a stop sequence
            delay_count_next = '0;
            if (!sda_in) begin
                scl_next   = 1'b0;
                nack_next  = 1'b0;
                phase_next = PH_IDLE;
                done       = 1'b1;
            end else if (poll_count_reg >= ack_poll_limit) begin
                nack_next        = 1'b1;
                scl_next         = 1'b0;
                sda_next         = 1'b0;
                delay_count_next = load_val;
                phase_next       = PH_SP1;
            end else begin
                poll_count_next = poll_count_reg + POLL_W'(1);
                phase_next      = PH_WA_POLL;
            end
        end else if (!expired) begin
            delay_count_next = delay_count_reg - DELAY_W'(1);
        end else begin
            // Delay ran out: take the next pin step
            delay_count_next = '0;
            case (phase_reg)
                PH_ST1: begin
                    sda_next         = 1'b0;
                    delay_count_next = load_val;
                    phase_next       = PH_ST2;
                end
                PH_ST2: begin
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                PH_SP1: begin
                    scl_next         = 1'b1;
                    delay_count_next = load_val;
                    phase_next       = PH_SP2;
                end
                PH_SP2: begin
                    sda_next         = 1'b1;
                    delay_count_next = load_val;
                    phase_next       = PH_SP3;
                end
                PH_SP3: begin
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                PH_SB_HI: begin
                    scl_next         = 1'b1;
                    delay_count_next = load_val;
                    phase_next       = PH_SB_LO;
                end
                PH_SB_LO: begin
                    scl_next       = 1'b0;
                    bit_index_next = bit_inc;
                    if (bit_inc >= BITS_PER_BYTE) begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end else begin
                        sda_next         = shifter_reg[BYTE_W-1];
                        shifter_next     = {shifter_reg[BYTE_W-2:0], 1'b0};
                        delay_count_next = load_val;
                        phase_next       = PH_SB_HI;
                    end
                end
                PH_WA1: begin
                    scl_next         = 1'b1;
                    delay_count_next = load_val;
                    phase_next       = PH_WA2;
                end
                PH_RB_HI: begin
                    scl_next         = 1'b1;
                    shifter_next     = {shifter_reg[BYTE_W-2:0], sda_in};
                    bit_index_next   = bit_inc;
                    delay_count_next = load_val;
                    phase_next       = PH_RB_LO;
                end
                PH_RB_LO: begin
                    scl_next         = 1'b0;
                    delay_count_next = load_val;
                    if (bit_index_reg < BITS_PER_BYTE) begin
                        phase_next = PH_RB_HI;
                    end else begin
                        rx_hold_next = shifter_reg;
                        sda_next     = !ack_choice_reg;
                        phase_next   = PH_RA1;
                    end
                end
                PH_RA1: begin
                    scl_next         = 1'b1;
                    delay_count_next = load_val;
                    phase_next       = PH_RA2;
                end
                PH_RA2: begin
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Advance the state on every accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            bit_index_reg   <= '0;
            shifter_reg     <= '0;
            delay_count_reg <= '0;
            poll_count_reg  <= '0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            ack_choice_reg  <= 1'b0;
            nack_reg        <= 1'b0;
            rx_hold_reg     <= '0;
        end else if (step_en) begin
            phase_reg       <= phase_next;
            bit_index_reg   <= bit_index_next;
            shifter_reg     <= shifter_next;
            delay_count_reg <= delay_count_next;
            poll_count_reg  <= poll_count_next;
            scl_reg         <= scl_next;
            sda_reg         <= sda_next;
            ack_choice_reg  <= ack_choice_next;
            nack_reg        <= nack_next;
            rx_hold_reg     <= rx_hold_next;
        end
    end

    // Result word from the updated state
    assign result.scl_out   = scl_next;
    assign result.sda_out   = sda_next;
    assign result.busy_res  = (phase_next != PH_IDLE);
    assign result.done_res  = done;
    assign result.nack      = nack_next;
    assign result.read_data = rx_hold_next;

endmodule

// ===== rtl/i2cm_out_buf.sv =====
// ----------------------------------------------------------------------------
// i2cm_out_buf
// Result register with valid/ready handshake; takes a new word in the same
// cycle the held one is taken.
// ----------------------------------------------------------------------------
module i2cm_out_buf
    import i2cm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t result_in,
    output logic    can_load,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t result_out
);

    logic    valid_reg;
    result_t data_reg;

    assign can_load   = !valid_reg || m_ready;
    assign m_valid    = valid_reg;
    assign result_out = data_reg;

    // Hold the word until taken, refill on load
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result_in;
        end
    end

endmodule

// ===== rtl/i2c_master_bit_engine.sv =====
// Each word is one bus tick; its result word is registered onto m_.
// Throughput: one word per cycle while s_ready is high; the phase sequencer
// plus the result register update once per accepted word.
// s_ready drops only while a result word is held and m_ready is low.
// Reset (aresetn, synchronous, active low): sequencer idle with SCL and SDA
// released, result register empty, delay_ticks 10, ack_poll_limit 250.
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// Tick-driven I2C master: start, stop, send byte, wait ack, read byte.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine
    import i2cm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CMD_W-1:0]      s_command,
    input  logic [BYTE_W-1:0]     s_data_byte,
    input  logic                  s_send_ack,
    input  logic                  s_sda_in,
    // Result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_scl_out,
    output logic                  m_sda_out,
    output logic                  m_busy_res,
    output logic                  m_done_res,
    output logic                  m_nack,
    output logic [BYTE_W-1:0]     m_read_data
);

    logic [DELAY_W-1:0] delay_ticks_reg;
    logic [POLL_W-1:0]  ack_poll_limit_reg;
    logic               can_load;
    logic               accept;
    result_t            core_result;
    result_t            out_result;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_ticks_reg    <= DELAY_TICKS_RESET;
            ack_poll_limit_reg <= ACK_POLL_LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DELAY_TICKS:    delay_ticks_reg    <= cfg_wdata;
                CFG_ACK_POLL_LIMIT: ack_poll_limit_reg <= cfg_wdata[POLL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_ready = can_load;
    assign accept  = s_valid && can_load;

    i2cm_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (accept),
        .command        (s_command),
        .data_byte      (s_data_byte),
        .send_ack       (s_send_ack),
        .sda_in         (s_sda_in),
        .delay_ticks    (delay_ticks_reg),
        .ack_poll_limit (ack_poll_limit_reg),
        .result         (core_result)
    );

    i2cm_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept),
        .result_in  (core_result),
        .can_load   (can_load),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .result_out (out_result)
    );

    assign m_scl_out   = out_result.scl_out;
    assign m_sda_out   = out_result.sda_out;
    assign m_busy_res  = out_result.busy_res;
    assign m_done_res  = out_result.done_res;
    assign m_nack      = out_result.nack;
    assign m_read_data = out_result.read_data;

endmodule

// ===== bench/i2c_master_bit_engine_tb.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_tb
// Self-checking bench for the tick-driven I2C master. Every accepted word is
// one bus tick; a predictor of the sequencer computes the pin levels and
// flags expected for that tick. The monitor compares each result word with
// them in order. Directed start, stop, send, wait-ack and read sequences come
// first, then random transactions under varying delay and poll-limit
// settings and handshake stalls.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_tb
    import i2cm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Command codes the block leaves unused
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    // SDA drive modes for non-poll ticks
    localparam int SDA_LOW  = 0;
    localparam int SDA_HIGH = 1;
    localparam int SDA_RAND = 2;

    // Poll count that no configured limit reaches: the slave never acknowledges
    localparam int ACK_NEVER = 1000;

    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] data;
        logic              send_ack;
        logic              sda_in;
    } bus_word_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_command   = CMD_TICK;
    logic [BYTE_W-1:0]     s_data_byte = '0;
    logic                  s_send_ack  = 1'b0;
    logic                  s_sda_in    = 1'b1;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic                  m_scl_out;
    logic                  m_sda_out;
    logic                  m_busy_res;
    logic                  m_done_res;
    logic                  m_nack;
    logic [BYTE_W-1:0]     m_read_data;

    // Words waiting for the driver and pin results waiting for the monitor
    bus_word_t tick_words_q[$];
    result_t   pin_results_q[$];

    int        src_idle_pct = 0;
    int        snk_idle_pct = 0;
    int        err_cnt      = 0;
    int        cmds_started = 0;
    int        stall_cycles = 0;
    bus_word_t drv_word;
    result_t   want_word;

    // Predicted sequencer state and configuration
    logic [DELAY_W-1:0] cfg_delay = DELAY_TICKS_RESET;
    logic [POLL_W-1:0]  cfg_limit = ACK_POLL_LIMIT_RESET;
    phase_t             seq_phase = PH_IDLE;
    logic [3:0]         bit_cnt   = '0;
    logic [BYTE_W-1:0]  shreg     = '0;
    logic [DELAY_W-1:0] dly_cnt   = '0;
    logic [POLL_W-1:0]  poll_cnt  = '0;
    logic               scl_lvl   = 1'b1;
    logic               sda_lvl   = 1'b1;
    logic               ack_sel   = 1'b0;
    logic               nack_lvl  = 1'b0;
    logic [BYTE_W-1:0]  rx_byte   = '0;

    i2c_master_bit_engine u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_data_byte (s_data_byte),
        .s_send_ack  (s_send_ack),
        .s_sda_in    (s_sda_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_scl_out   (m_scl_out),
        .m_sda_out   (m_sda_out),
        .m_busy_res  (m_busy_res),
        .m_done_res  (m_done_res),
        .m_nack      (m_nack),
        .m_read_data (m_read_data)
    );

    always #6 aclk = ~aclk;

    // Enter a delayed step; a zero setting counts as one tick
    function automatic void load_delay(input phase_t nxt);
        dly_cnt   = (cfg_delay == '0) ? 16'd1 : cfg_delay;
        seq_phase = nxt;
    endfunction

    function automatic void begin_stop();
        scl_lvl = 1'b0;
        sda_lvl = 1'b0;
        load_delay(PH_SP1);
    endfunction

    // One look at SDA in the acknowledge slot; returns 1 when the command ends
    function automatic logic poll_ack(input logic sda);
        if (!sda) begin
            scl_lvl   = 1'b0;
            nack_lvl  = 1'b0;
            seq_phase = PH_IDLE;
            return 1'b1;
        end
        if (poll_cnt >= cfg_limit) begin
            nack_lvl = 1'b1;
            begin_stop();
        end else begin
            poll_cnt  = poll_cnt + 1'b1;
            seq_phase = PH_WA_POLL;
        end
        return 1'b0;
    endfunction

    // Advance the predicted sequencer by one tick and return its pin result
    function automatic result_t bus_tick(input bus_word_t w);
        logic    fin;
        result_t r;
        fin = 1'b0;
        if (seq_phase == PH_IDLE) begin
            case (w.cmd)
                CMD_START: begin
                    sda_lvl = 1'b1;
                    scl_lvl = 1'b1;
                    load_delay(PH_ST1);
                end
                CMD_STOP: begin
                    begin_stop();
                end
                CMD_SEND: begin
                    scl_lvl = 1'b0;
                    sda_lvl = w.data[7];
                    shreg   = {w.data[6:0], 1'b0};
                    bit_cnt = '0;
                    load_delay(PH_SB_HI);
                end
                CMD_WAIT: begin
                    nack_lvl = 1'b0;
                    poll_cnt = '0;
                    sda_lvl  = 1'b1;
                    load_delay(PH_WA1);
                end
                CMD_READ: begin
                    sda_lvl = 1'b1;
                    scl_lvl = 1'b0;
                    ack_sel = w.send_ack;
                    shreg   = '0;
                    bit_cnt = '0;
                    load_delay(PH_RB_HI);
                end
                default: begin
                end
            endcase
        end else if (seq_phase == PH_WA_POLL) begin
            fin = poll_ack(w.sda_in);
        end else if (dly_cnt > 16'd1) begin
            dly_cnt = dly_cnt - 1'b1;
        end else begin
            dly_cnt = '0;
            case (seq_phase)
                PH_ST1: begin
                    sda_lvl = 1'b0;
                    load_delay(PH_ST2);
                end
                PH_ST2: begin
                    scl_lvl   = 1'b0;
                    seq_phase = PH_IDLE;
                    fin       = 1'b1;
                end
                PH_SP1: begin
                    scl_lvl = 1'b1;
                    load_delay(PH_SP2);
                end
                PH_SP2: begin
                    sda_lvl = 1'b1;
                    load_delay(PH_SP3);
                end
                PH_SP3: begin
                    seq_phase = PH_IDLE;
                    fin       = 1'b1;
                end
                PH_SB_HI: begin
                    scl_lvl = 1'b1;
                    load_delay(PH_SB_LO);
                end
                PH_SB_LO: begin
                    scl_lvl = 1'b0;
                    bit_cnt = bit_cnt + 1'b1;
                    if (bit_cnt >= BITS_PER_BYTE) begin
                        seq_phase = PH_IDLE;
                        fin       = 1'b1;
                    end else begin
                        sda_lvl = shreg[7];
                        shreg   = {shreg[6:0], 1'b0};
                        load_delay(PH_SB_HI);
                    end
                end
                PH_WA1: begin
                    scl_lvl = 1'b1;
                    load_delay(PH_WA2);
                end
                PH_WA2: begin
                    fin = poll_ack(w.sda_in);
                end
                PH_RB_HI: begin
                    scl_lvl = 1'b1;
                    shreg   = {shreg[6:0], w.sda_in};
                    bit_cnt = bit_cnt + 1'b1;
                    load_delay(PH_RB_LO);
                end
                PH_RB_LO: begin
                    scl_lvl = 1'b0;
                    if (bit_cnt < BITS_PER_BYTE) begin
                        load_delay(PH_RB_HI);
                    end else begin
                        rx_byte = shreg;
                        sda_lvl = ~ack_sel;
                        load_delay(PH_RA1);
                    end
                end
                PH_RA1: begin
                    scl_lvl = 1'b1;
                    load_delay(PH_RA2);
                end
                PH_RA2: begin
                    scl_lvl   = 1'b0;
                    seq_phase = PH_IDLE;
                    fin       = 1'b1;
                end
                default: begin
                    seq_phase = PH_IDLE;
                end
            endcase
        end
        r.scl_out   = scl_lvl;
        r.sda_out   = sda_lvl;
        r.busy_res  = (seq_phase != PH_IDLE);
        r.done_res  = fin;
        r.nack      = nack_lvl;
        r.read_data = rx_byte;
        return r;
    endfunction

    // Queue one tick word together with the pins it should produce
    function automatic void push_word(input logic [CMD_W-1:0] cmd, input logic [7:0] data,
                                      input logic sack, input logic sda);
        bus_word_t w;
        w.cmd      = cmd;
        w.data     = data;
        w.send_ack = sack;
        w.sda_in   = sda;
        tick_words_q.push_back(w);
        pin_results_q.push_back(bus_tick(w));
    endfunction

    function automatic logic pick_sda(input int mode);
        if (mode == SDA_LOW)
            return 1'b0;
        if (mode == SDA_HIGH)
            return 1'b1;
        return 1'($urandom);
    endfunction

    // Issue a command, then tick until the sequencer is idle again.
    // The slave pulls SDA low on the poll after ack_after high polls.
    function automatic void run_cmd(input logic [CMD_W-1:0] cmd, input logic [7:0] data,
                                    input logic sack, input int ack_after, input int sda_mode);
        int               polls;
        logic             sda;
        logic [CMD_W-1:0] stray;
        polls = 0;
        push_word(cmd, data, sack, pick_sda(sda_mode));
        if (seq_phase != PH_IDLE)
            cmds_started++;
        while (seq_phase != PH_IDLE) begin
            if (seq_phase == PH_WA_POLL || (seq_phase == PH_WA2 && dly_cnt <= 16'd1)) begin
                sda = (polls >= ack_after) ? 1'b0 : 1'b1;
                polls++;
            end else begin
                sda = pick_sda(sda_mode);
            end
            // commands while busy must be ignored
            stray = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : CMD_TICK;
            push_word(stray, 8'($urandom), 1'($urandom), sda);
        end
    endfunction

    function automatic int pick_ack();
        int roll;
        roll = $urandom_range(9);
        if (roll < 5)
            return 0;
        if (roll < 8)
            return $urandom_range(1, 4);
        return ACK_NEVER;
    endfunction

    // Mostly complete transactions with random content, some stray commands
    function automatic void random_traffic(input int n_cmds);
        int goal;
        int n;
        goal = cmds_started + n_cmds;
        while (cmds_started < goal) begin
            if ($urandom_range(9) < 8) begin
                run_cmd(CMD_START, 8'($urandom), 1'($urandom), 0, SDA_RAND);
                run_cmd(CMD_SEND, 8'($urandom), 1'($urandom), 0, SDA_RAND);
                run_cmd(CMD_WAIT, 8'($urandom), 1'($urandom), pick_ack(), SDA_RAND);
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(1) == 0) begin
                        run_cmd(CMD_SEND, 8'($urandom), 1'($urandom), 0, SDA_RAND);
                        run_cmd(CMD_WAIT, 8'($urandom), 1'($urandom), pick_ack(), SDA_RAND);
                    end else begin
                        run_cmd(CMD_READ, 8'($urandom), 1'($urandom), 0, SDA_RAND);
                    end
                end
                run_cmd(CMD_STOP, 8'($urandom), 1'($urandom), 0, SDA_RAND);
            end else begin
                run_cmd(3'($urandom_range(7)), 8'($urandom), 1'($urandom), pick_ack(),
                        SDA_RAND);
            end
        end
    endfunction

    // Hold until every queued word has its result, then let the pipe settle
    task automatic wait_drained();
        while (tick_words_q.size() != 0 || pin_results_q.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic program_timing(input logic [DELAY_W-1:0] dly, input logic [POLL_W-1:0] lim);
        write_reg(CFG_DELAY_TICKS, dly);
        write_reg(CFG_ACK_POLL_LIMIT, {{(CFG_DATA_W-POLL_W){1'b0}}, lim});
        cfg_delay = dly;
        cfg_limit = lim;
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    // Feed tick words, holding each until it is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (tick_words_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                drv_word = tick_words_q.pop_front();
                s_valid     <= 1'b1;
                s_command   <= drv_word.cmd;
                s_data_byte <= drv_word.data;
                s_send_ack  <= drv_word.send_ack;
                s_sda_in    <= drv_word.sda_in;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Compare each result word with the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pin_results_q.size() == 0) begin
                    $error("result word arrived with nothing expected");
                    err_cnt++;
                end else begin
                    want_word = pin_results_q.pop_front();
                    check_field("scl_out", want_word.scl_out, m_scl_out);
                    check_field("sda_out", want_word.sda_out, m_sda_out);
                    check_field("busy_res", want_word.busy_res, m_busy_res);
                    check_field("done_res", want_word.done_res, m_done_res);
                    check_field("nack", want_word.nack, m_nack);
                    check_field("read_data", want_word.read_data, m_read_data);
                end
            end
            m_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Abort when neither channel moves a word for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Sender idles rarely, receiver often; reset timing first
        src_idle_pct = 13;
        snk_idle_pct = 85;
        run_cmd(CMD_TICK, 8'h00, 1'b0, 0, SDA_HIGH);
        run_cmd(CMD_SPARE6, 8'hFF, 1'b1, 0, SDA_LOW);
        run_cmd(CMD_SPARE7, 8'h00, 1'b0, 0, SDA_RAND);
        run_cmd(CMD_START, 8'h00, 1'b0, 0, SDA_RAND);
        run_cmd(CMD_WAIT, 8'h00, 1'b0, 3, SDA_RAND);
        run_cmd(CMD_STOP, 8'h00, 1'b0, 0, SDA_RAND);
        wait_drained();

        // Shortest delay, zero poll limit: a high SDA on the first poll times out
        program_timing(16'd1, 8'd0);
        run_cmd(CMD_START, 8'h00, 1'b0, 0, SDA_RAND);
        run_cmd(CMD_SEND, 8'h5A, 1'b0, 0, SDA_RAND);
        run_cmd(CMD_WAIT, 8'h00, 1'b0, ACK_NEVER, SDA_RAND);
        run_cmd(CMD_WAIT, 8'h00, 1'b0, 0, SDA_RAND);
        run_cmd(CMD_READ, 8'h00, 1'b1, 0, SDA_HIGH);
        run_cmd(CMD_READ, 8'h00, 1'b0, 0, SDA_LOW);
        run_cmd(CMD_STOP, 8'h00, 1'b0, 0, SDA_RAND);
        random_traffic(5);
        wait_drained();

        // Swap the stall pattern; zero delay acts as one tick
        src_idle_pct = 85;
        snk_idle_pct = 13;
        program_timing(16'd0, 8'd3);
        run_cmd(CMD_START, 8'h00, 1'b0, 0, SDA_RAND);
        run_cmd(CMD_STOP, 8'h00, 1'b0, 0, SDA_RAND);
        random_traffic(4);
        wait_drained();

        // Largest poll limit with a slave that never answers
        program_timing(16'd1, 8'd255);
        run_cmd(CMD_WAIT, 8'h00, 1'b0, ACK_NEVER, SDA_RAND);
        wait_drained();

        // No stalls on either side
        src_idle_pct = 0;
        snk_idle_pct = 0;
        program_timing(16'd3, 8'd1);
        random_traffic(3);
        wait_drained();
        repeat (4) @(posedge aclk);

        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
